[rtl/binary_opening_3x3_mask_assert.svh]
// Assertion macros for the binary opening block.
// Used by the top level and the output buffer; no other dependencies.
`ifndef BINARY_OPENING_3X3_MASK_ASSERT_SVH
`define BINARY_OPENING_3X3_MASK_ASSERT_SVH
`ifndef SYNTHESIS
`define BO3M_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BO3M_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`else
`define BO3M_ASSERT(lbl, clk, rst_n, prop, msg)
`define BO3M_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg)
`endif
`endif

[rtl/bo3m_pkg.sv]
// Shared constants and types for the binary opening block.
// No dependencies.
package bo3m_pkg;

    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 12;
    localparam int MIN_SIZE     = 3;
    localparam int RESET_WIDTH  = 256;
    localparam int RESET_HEIGHT = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

[rtl/binary_opening_3x3_mask.sv]
// Top level of the 3x3 binary opening mask over a raster pixel stream.
// Depends on bo3m_pkg, bo3m_linebuf, bo3m_skid and the assertion macro header.
`include "binary_opening_3x3_mask_assert.svh"

// Takes one pixel per clock cycle and gives one result per cycle once the pipeline
// is primed and while the output buffer has room. Each request is handled in the
// cycle it is accepted: one line memory of MAX_WIDTH words, addressed by column, is
// read ahead and written back in the accepting cycle, so a single read and a single
// write per cycle set the rate. A result leaves 2*W+2 requests after its pixel, so
// the host sends 2*W+2 flush requests after each frame; a two-entry output buffer
// keeps the input side running while a result waits. Configuration writes restart
// the frame. The memory needs no clearing after reset.
module binary_opening_3x3_mask #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bo3m_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bo3m_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [TDATA_W-1:0]               s_axis_tdata,  // pixel_value
    input  logic                             s_axis_tuser,  // flush
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [TDATA_W-1:0]               m_axis_tdata,  // opened_value
    output logic                             m_axis_tlast
);

    import bo3m_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EFF_W = $clog2(MAX_WIDTH + 1);
    localparam int LB_W  = 2 * PIXEL_BITS + 4;
    localparam int OUT_W = PIXEL_BITS + 1;
    localparam logic [EFF_W-1:0] RESET_EFF_W =
        EFF_W'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);
    localparam logic [CFG_DATA_W-1:0] RESET_EFF_H = CFG_DATA_W'(RESET_HEIGHT);

    function automatic logic [EFF_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] d);
        logic [EFF_W-1:0] res;
        if (int'(d) < MIN_SIZE) begin
            res = EFF_W'(MIN_SIZE);
        end else if (int'(d) > MAX_WIDTH) begin
            res = EFF_W'(MAX_WIDTH);
        end else begin
            res = EFF_W'(d);
        end
        return res;
    endfunction

    logic [EFF_W-1:0]      r_eff_w;
    logic [EFF_W-1:0]      n_eff_w;
    logic [CFG_DATA_W-1:0] r_eff_h;
    logic [CFG_DATA_W-1:0] n_eff_h;
    logic [COL_W-1:0]      r_col;
    logic [COL_W-1:0]      n_col;
    logic [ROW_W-1:0]      r_row;
    logic [ROW_W-1:0]      n_row;
    logic [2:0]            r_rawc1;
    logic [2:0]            r_rawc2;
    logic [2:0]            r_eroc1;
    logic [2:0]            r_eroc2;
    logic [PIXEL_BITS-1:0] r_vd1;
    logic [PIXEL_BITS-1:0] r_vd2;

    logic                  w_accept;
    logic [LB_W-1:0]       w_rd_data;
    logic [LB_W-1:0]       w_wr_data;
    logic                  w_rd_raw1;
    logic                  w_rd_raw2;
    logic                  w_rd_ero1;
    logic                  w_rd_ero2;
    logic [PIXEL_BITS-1:0] w_rd_val1;
    logic [PIXEL_BITS-1:0] w_rd_val2;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [EFF_W-1:0]      w_col_ext;
    logic                  w_col_last;
    logic [ROW_W-1:0]      w_h;
    logic                  w_raw;
    logic [2:0]            w_rawc;
    logic                  w_ero_in;
    logic                  w_ero;
    logic [2:0]            w_eroc;
    logic                  w_dil_in;
    logic                  w_dil;
    logic                  w_produce;
    logic                  w_frame_end;
    logic [PIXEL_BITS-1:0] w_out_value;
    logic [OUT_W-1:0]      w_out_data;
    logic                  w_skid_ready;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_rd_raw1 = w_rd_data[0];
        w_rd_raw2 = w_rd_data[1];
        w_rd_ero1 = w_rd_data[2];
        w_rd_ero2 = w_rd_data[3];
        w_rd_val1 = w_rd_data[4 +: PIXEL_BITS];
        w_rd_val2 = w_rd_data[4 + PIXEL_BITS +: PIXEL_BITS];

        w_pix      = s_axis_tuser ? '0 : s_axis_tdata[PIXEL_BITS-1:0];
        w_col_ext  = EFF_W'(r_col);
        w_col_last = (w_col_ext == r_eff_w - EFF_W'(1));
        w_h        = ROW_W'(r_eff_h);

        w_raw = (r_row < w_h) && (r_row != '0) && (r_row != w_h - ROW_W'(1))
             && (r_col != '0) && !w_col_last && (w_pix != '0);
        w_rawc = {w_raw, w_rd_raw1, w_rd_raw2};

        w_ero_in = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2))
                && (r_row <= w_h - ROW_W'(1));
        w_ero  = w_ero_in && (&{w_rawc, r_rawc1, r_rawc2});
        w_eroc = {w_ero, w_rd_ero1, w_rd_ero2};

        w_dil_in = ((r_col >= COL_W'(3)) && (r_row >= ROW_W'(3)) && (r_row <= w_h))
                || ((r_col == '0) && (r_row >= ROW_W'(4)) && (r_row <= w_h + ROW_W'(1)));
        w_dil = w_dil_in && (|{w_eroc, r_eroc1, r_eroc2});

        w_produce   = (r_row > ROW_W'(2)) || ((r_row == ROW_W'(2)) && (r_col >= COL_W'(2)));
        w_frame_end = (r_row == w_h + ROW_W'(2)) && (r_col == COL_W'(1));
        w_out_value = w_dil ? r_vd2 : '0;
        w_out_data  = {w_frame_end, w_out_value};

        w_wr_data = {w_rd_val1, w_pix, w_rd_ero1, w_ero, w_rd_raw1, w_raw};
    end

    always_comb begin
        n_eff_w = r_eff_w;
        n_eff_h = r_eff_h;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_IMAGE_WIDTH: begin
                    n_eff_w = clamp_width(i_cfg_data);
                end
                REG_IMAGE_HEIGHT: begin
                    n_eff_h = (i_cfg_data < CFG_DATA_W'(MIN_SIZE))
                            ? CFG_DATA_W'(MIN_SIZE) : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The next column also drives the memory read address, so data for the
    // following request is already read from the memory when it comes.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (!i_rst_n || i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (w_frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (w_col_last) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= RESET_EFF_W;
            r_eff_h <= RESET_EFF_H;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_eff_w <= n_eff_w;
            r_eff_h <= n_eff_h;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rawc1 <= w_rawc;
            r_rawc2 <= r_rawc1;
            r_eroc1 <= w_eroc;
            r_eroc2 <= r_eroc1;
            r_vd1   <= w_rd_val2;
            r_vd2   <= r_vd1;
        end
    end

    bo3m_linebuf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LB_W)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_addr (n_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_col),
        .i_wr_data (w_wr_data)
    );

    logic [OUT_W-1:0] w_skid_data;

    bo3m_skid #(
        .DATA_W (OUT_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_produce),
        .i_data  (w_out_data),
        .o_ready (w_skid_ready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_skid_data),
        .i_ready (m_axis_tready)
    );

    assign s_axis_tready = w_skid_ready;
    assign m_axis_tdata  = TDATA_W'(w_skid_data[PIXEL_BITS-1:0]);
    assign m_axis_tlast  = w_skid_data[PIXEL_BITS];

    `BO3M_ASSERT(a_col_range, i_clk, i_rst_n, w_col_ext < r_eff_w, "column counter beyond width")
    `BO3M_ASSERT(a_row_range, i_clk, i_rst_n, r_row <= w_h + ROW_W'(2), "row counter beyond frame")
    `BO3M_ASSERT_IMP(a_ero_centre, i_clk, i_rst_n, w_accept && w_ero, r_rawc1[1], "eroded bit without centre")

endmodule

[rtl/bo3m_linebuf.sv]
// Column-addressed line memory with one registered read port and one write port.
// No dependencies.
module bo3m_linebuf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 36,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bo3m_skid.sv]
// Two-entry output buffer that decouples the result stream from the input side.
// Depends on the assertion macro header.
`include "binary_opening_3x3_mask_assert.svh"

module bo3m_skid #(
    parameter int DATA_W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);

    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic [DATA_W-1:0] r_q0;
    logic [DATA_W-1:0] r_q1;
    logic              w_pop;

    always_comb begin
        w_pop = (r_cnt != 2'd0) && i_ready;
        n_cnt = r_cnt + 2'(i_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
                if (i_push) begin
                    r_q1 <= i_data;
                end
            end else if (i_push) begin
                r_q0 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;

    `BO3M_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !i_push, "push into full buffer")

endmodule
